/* rtl/rmfp_pkg.sv */
// Shared types, constants and codes for the rotated framebuffer plotter.
package rmfp_pkg;

	// Panel geometry and the derived store size.
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 296;
	localparam int STORE_BYTES  = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
	localparam int ADDR_W       = $clog2(STORE_BYTES);
	localparam int PIX_W        = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

	// Field widths fixed by the interface.
	localparam int COORD_W = 11;
	localparam int IDX_W   = 13;
	localparam int MAP_W   = 13;

	// Byte constants.
	localparam logic [7:0] BYTE_MSB  = 8'h80;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// Command codes carried in tuser.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_PLOT  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROTATION = 2'd0;
	localparam logic [1:0] CFG_INVERT   = 2'd1;

	// Rotation codes.
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Input item payload, first field in the lowest bits.
	typedef struct packed {
		logic [3:0]                pad;
		logic [IDX_W-1:0]          byte_index;
		logic                      colored;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] x_coord;
	} in_data_t;

	// Result item payload, first field in the lowest bits.
	typedef struct packed {
		logic [2:0]       pad;
		logic [IDX_W-1:0] read_index;
		logic [7:0]       read_data;
	} out_data_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_MAP,
		ST_ADDR,
		ST_MODIFY,
		ST_READ,
		ST_REPLY
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_wr;
		logic map_en;
		logic addr_en;
		logic wr_plot;
		logic rd_issue;
		logic out_load;
	} rmfp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} rmfp_status_t;

endpackage

/* rtl/rmfp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rmfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/rmfp_ctrl.sv */
// Controller state machine that sequences clear, plot and read commands.
module rmfp_ctrl
	import rmfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic [1:0]   command,
	input  rmfp_status_t status,
	output logic         s_tready,
	output rmfp_cmd_t    ctrl
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands to the datapath.
	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.load = 1'b1;
					case (command)
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_PLOT:  state_d = ST_MAP;
						CMD_READ:  state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_MAP: begin
				ctrl.map_en = 1'b1;
				state_d     = ST_ADDR;
			end
			ST_ADDR: begin
				ctrl.addr_en = 1'b1;
				state_d      = ST_MODIFY;
			end
			ST_MODIFY: begin
				ctrl.wr_plot = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_READ: begin
				ctrl.rd_issue = 1'b1;
				state_d       = ST_REPLY;
			end
			ST_REPLY: begin
				if (status.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/rmfp_datapath.sv */
// Datapath: configuration, rotation mapping, byte addressing, store and result register.
module rmfp_datapath
	import rmfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  rmfp_cmd_t    ctrl,
	output rmfp_status_t status,
	input  in_data_t     in_data,
	input  logic         cfg_valid,
	input  logic [1:0]   cfg_index,
	input  logic [1:0]   cfg_data,
	output logic         m_tvalid,
	input  logic         m_tready,
	output out_data_t    m_tdata
);

	localparam logic signed [MAP_W-1:0] W_S = MAP_W'(PANEL_WIDTH);
	localparam logic signed [MAP_W-1:0] H_S = MAP_W'(PANEL_HEIGHT);

	logic [1:0]              rotation_q;
	logic                    invert_q;
	logic signed [MAP_W-1:0] x_q;
	logic signed [MAP_W-1:0] y_q;
	logic                    colored_q;
	logic [IDX_W-1:0]        byte_index_q;
	logic [ADDR_W-1:0]       clr_cnt_q;

	logic signed [MAP_W-1:0] mx_s1;
	logic signed [MAP_W-1:0] my_s1;
	logic                    ok_s1;
	logic signed [MAP_W-1:0] mx_d;
	logic signed [MAP_W-1:0] my_d;
	logic                    ok_d;

	logic [PIX_W-1:0]  lin;
	logic [ADDR_W-1:0] plot_addr;
	logic              plot_ok;
	logic [ADDR_W-1:0] addr_s2;
	logic [7:0]        mask_s2;
	logic              valid_s2;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;
	logic              set_bit;
	logic [7:0]        bg_byte;
	logic              read_ok;
	logic              m_tvalid_q;
	out_data_t         m_tdata_q;

	// Configuration registers; writes with an unknown index are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_270;
			invert_q   <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ROTATION) begin
				rotation_q <= cfg_data;
			end else if (cfg_index == CFG_INVERT) begin
				invert_q <= cfg_data[0];
			end
		end
	end

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q          <= MAP_W'(in_data.x_coord);
			y_q          <= MAP_W'(in_data.y_coord);
			colored_q    <= in_data.colored;
			byte_index_q <= in_data.byte_index;
		end
	end

	// Clear sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctrl.load) begin
			clr_cnt_q <= '0;
		end else if (ctrl.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	assign status.clr_last = (clr_cnt_q == ADDR_W'(STORE_BYTES - 1));

	// Bounds check against the rotated size and map to panel coordinates.
	always_comb begin
		case (rotation_q)
			ROT_0: begin
				ok_d = (x_q >= 0) && (x_q < W_S) && (y_q >= 0) && (y_q < H_S);
				mx_d = x_q;
				my_d = y_q;
			end
			ROT_90: begin
				ok_d = (x_q >= 0) && (x_q < H_S) && (y_q >= 0) && (y_q < W_S);
				mx_d = W_S - y_q;
				my_d = x_q;
			end
			ROT_180: begin
				ok_d = (x_q >= 0) && (x_q < W_S) && (y_q >= 0) && (y_q < H_S);
				mx_d = W_S - x_q;
				my_d = H_S - y_q;
			end
			default: begin
				ok_d = (x_q >= 0) && (x_q < H_S) && (y_q >= 0) && (y_q < W_S);
				mx_d = y_q;
				my_d = H_S - x_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.map_en) begin
			mx_s1 <= mx_d;
			my_s1 <= my_d;
			ok_s1 <= ok_d;
		end
	end

	// Linear pixel index, byte address and bit mask of the mapped point.
	assign lin       = PIX_W'(mx_s1) + PIX_W'(my_s1) * PIX_W'(PANEL_WIDTH);
	assign plot_addr = ADDR_W'(lin >> 3);
	assign plot_ok   = ok_s1 && (mx_s1 >= 0) && (mx_s1 < W_S) && (my_s1 >= 0)
		&& (my_s1 < H_S) && (32'(lin >> 3) < STORE_BYTES);

	always_ff @(posedge clk) begin
		if (ctrl.addr_en) begin
			addr_s2  <= plot_addr;
			mask_s2  <= BYTE_MSB >> mx_s1[2:0];
			valid_s2 <= plot_ok;
		end
	end

	// Ink polarity and background byte.
	assign set_bit = invert_q ? colored_q : !colored_q;
	assign bg_byte = invert_q ? BYTE_ZERO : BYTE_ONES;
	assign read_ok = (32'(byte_index_q) < STORE_BYTES);

	// Store port selection: clear sweep or plot write; plot or read fetch.
	always_comb begin
		we    = 1'b0;
		waddr = addr_s2;
		wdata = set_bit ? (rdata | mask_s2) : (rdata & ~mask_s2);
		if (ctrl.clr_wr) begin
			we    = 1'b1;
			waddr = clr_cnt_q;
			wdata = bg_byte;
		end else if (ctrl.wr_plot && valid_s2) begin
			we = 1'b1;
		end
		re    = ctrl.addr_en || ctrl.rd_issue;
		raddr = ctrl.rd_issue ? ADDR_W'(byte_index_q) : plot_addr;
	end

	rmfp_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result register; a new item may be taken while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata_q.pad        <= '0;
			m_tdata_q.read_index <= byte_index_q;
			m_tdata_q.read_data  <= read_ok ? rdata : BYTE_ZERO;
		end
	end

	assign status.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;

endmodule

/* rtl/rotated_mono_framebuffer_plotter.sv */
// Top level of the rotated one-bit framebuffer plotter.
// The block holds a one-bit-per-pixel image of the panel in a byte-wide RAM,
// pixels packed MSB first. It takes one command at a time on the input stream:
// a plot maps the point, then forms the address and fetches the byte, then
// does a read-modify-write of one byte through the single RAM write port; a read
// fetches the byte, then waits as needed for the result register to drain; a
// clear sweeps the RAM one byte per cycle, writing all STORE_BYTES bytes (4736
// for a 128 by 296 panel). A read result sits in an output register, so the next
// command is taken while it waits. Configuration is always ready and must be
// written while the block is idle.
module rotated_mono_framebuffer_plotter
	import rmfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // x_coord, y_coord, colored, byte_index, zero fill
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_data, read_index, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	rmfp_cmd_t    ctrl;
	rmfp_status_t status;
	in_data_t     in_data;
	out_data_t    out_data;

	assign in_data   = s_tdata;
	assign m_tdata   = out_data;
	assign cfg_ready = 1'b1;

	// Command sequencing.
	rmfp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.command (s_tuser),
		.status  (status),
		.s_tready(s_tready),
		.ctrl    (ctrl)
	);

	// Mapping, store and result register.
	rmfp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.status   (status),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (out_data)
	);

endmodule
